// ===== hw/rtl/ssbf_pkg.sv =====
// ssbf_pkg: shared types, constants and functions of the seven-segment blink formatter
// no dependencies; used by every rtl module of the block

package ssbf_pkg;

	// display geometry and fixed codes
	localparam int          DIGIT_COUNT       = 4;
	localparam logic [15:0] HALF_PERIOD_RESET = 16'd500;
	localparam logic [7:0]  DOT_BIT           = 8'h80;
	localparam logic [6:0]  SEG_OFF           = 7'h00;

	// one decimal digit and a four digit word, index 0 is the leftmost digit
	typedef logic [3:0] bcd_t;
	typedef bcd_t [DIGIT_COUNT-1:0] bcd_word_t;

	// per-item control carried alongside the value through the pipeline
	typedef struct packed {
		logic [2:0] blink_position;
		logic [2:0] dot_position;
		logic       blank;
	} ssbf_ctl_t;

	// one digit taken off the top of a remainder
	typedef struct packed {
		bcd_t        digit;
		logic [16:0] rest;
	} split_t;

	// digit = how many multiples of unit fit (0..9), rest = what is left
	// nine independent compares against constant multiples, then one subtract
	function automatic split_t digit_split(input logic [16:0] r, input logic [16:0] unit);
		split_t res;
		res.digit = '0;
		res.rest  = r;
		for (int k = 1; k <= 9; k++) begin
			if ({15'd0, r} >= 32'(k) * {15'd0, unit}) begin
				res.digit = 4'(k);
				res.rest  = r - 17'(32'(k) * {15'd0, unit});
			end
		end
		return res;
	endfunction

	// seven-segment code, bit 0 = segment a ... bit 6 = segment g
	function automatic logic [6:0] seg_code(input bcd_t d);
		logic [6:0] code;
		case (d)
			4'd0:    code = 7'h3F;
			4'd1:    code = 7'h06;
			4'd2:    code = 7'h5B;
			4'd3:    code = 7'h4F;
			4'd4:    code = 7'h66;
			4'd5:    code = 7'h6D;
			4'd6:    code = 7'h7D;
			4'd7:    code = 7'h07;
			4'd8:    code = 7'h7F;
			4'd9:    code = 7'h6F;
			default: code = SEG_OFF;
		endcase
		return code;
	endfunction

endpackage

// ===== hw/rtl/ssbf_if.sv =====
// ssbf_if: valid/ready channel interfaces of the seven-segment blink formatter
// tick input, result output and configuration write; depends on nothing

// timer tick items
interface ssbf_tick_if;
	logic        valid;
	logic        ready;
	logic [15:0] value;
	logic [2:0]  blink_position;
	logic [2:0]  dot_position;

	modport source (output valid, value, blink_position, dot_position, input ready);
	modport sink   (input valid, value, blink_position, dot_position, output ready);
endinterface

// formatted display items
interface ssbf_result_if;
	logic       valid;
	logic       ready;
	logic [7:0] digit_one;
	logic [7:0] digit_two;
	logic [7:0] digit_three;
	logic [7:0] digit_four;
	logic       blank_phase;

	modport source (output valid, digit_one, digit_two, digit_three, digit_four, blank_phase,
		input ready);
	modport sink   (input valid, digit_one, digit_two, digit_three, digit_four, blank_phase,
		output ready);
endinterface

// half period register writes
interface ssbf_cfg_if;
	logic        valid;
	logic        ready;
	logic [15:0] half_period;

	modport source (output valid, half_period, input ready);
	modport sink   (input valid, half_period, output ready);
endinterface

// ===== hw/rtl/ssbf_phase.sv =====
// ssbf_phase: half period register, tick counter and blink phase
// depends on ssbf_pkg

module ssbf_phase (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_half_period,
	input  logic        tick_fire,
	output logic        blank
);

	logic [15:0] half_period_q;
	logic [15:0] count_q;
	logic        showing_full_q;
	logic [15:0] count_inc;

	// register writes are always taken
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_period_q <= ssbf_pkg::HALF_PERIOD_RESET;
		end else if (cfg_valid) begin
			half_period_q <= cfg_half_period;
		end
	end

	// the item sees the phase held before its own tick
	assign blank     = !showing_full_q;
	assign count_inc = count_q + 16'd1;

	// count ticks, toggle phase when the count reaches the half period
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q        <= '0;
			showing_full_q <= 1'b0;
		end else if (tick_fire) begin
			if (count_inc >= half_period_q) begin
				count_q        <= '0;
				showing_full_q <= !showing_full_q;
			end else begin
				count_q <= count_inc;
			end
		end
	end

endmodule

// ===== hw/rtl/ssbf_bcd.sv =====
// ssbf_bcd: pipelined value mod 10000 and decimal digit split, one digit place per stage
// depends on ssbf_pkg

module ssbf_bcd (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  up_valid,
	output logic                  up_ready,
	input  logic [15:0]           up_value,
	input  ssbf_pkg::ssbf_ctl_t   up_ctl,
	output logic                  dn_valid,
	input  logic                  dn_ready,
	output ssbf_pkg::bcd_word_t   dn_digits,
	output ssbf_pkg::ssbf_ctl_t   dn_ctl
);

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic go_s1, go_s2, go_s3, go_s4, go_s5;

	logic [15:0]         value_s1;
	logic [13:0]         num_s2;
	logic [9:0]          rem_s3;
	logic [6:0]          rem_s4;
	ssbf_pkg::bcd_t      d0_s3, d0_s4, d0_s5;
	ssbf_pkg::bcd_t      d1_s4, d1_s5;
	ssbf_pkg::bcd_t      d2_s5, d3_s5;
	ssbf_pkg::ssbf_ctl_t ctl_s1, ctl_s2, ctl_s3, ctl_s4, ctl_s5;

	ssbf_pkg::split_t sp_mod, sp_th, sp_hu, sp_te;

	// a stage loads when it is empty or its item moves on
	assign go_s5    = !v_s5 || dn_ready;
	assign go_s4    = !v_s4 || go_s5;
	assign go_s3    = !v_s3 || go_s4;
	assign go_s2    = !v_s2 || go_s3;
	assign go_s1    = !v_s1 || go_s2;
	assign up_ready = go_s1;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (go_s1) v_s1 <= up_valid;
			if (go_s2) v_s2 <= v_s1;
			if (go_s3) v_s3 <= v_s2;
			if (go_s4) v_s4 <= v_s3;
			if (go_s5) v_s5 <= v_s4;
		end
	end

	// digit splits, each against constant multiples of one place value
	always_comb begin
		sp_mod = ssbf_pkg::digit_split({1'b0, value_s1}, 17'd10000);
		sp_th  = ssbf_pkg::digit_split({3'd0, num_s2}, 17'd1000);
		sp_hu  = ssbf_pkg::digit_split({7'd0, rem_s3}, 17'd100);
		sp_te  = ssbf_pkg::digit_split({10'd0, rem_s4}, 17'd10);
	end

	// payload stages
	always_ff @(posedge clk) begin
		if (go_s1) begin
			value_s1 <= up_value;
			ctl_s1   <= up_ctl;
		end
		if (go_s2) begin
			num_s2 <= sp_mod.rest[13:0];
			ctl_s2 <= ctl_s1;
		end
		if (go_s3) begin
			d0_s3  <= sp_th.digit;
			rem_s3 <= sp_th.rest[9:0];
			ctl_s3 <= ctl_s2;
		end
		if (go_s4) begin
			d0_s4  <= d0_s3;
			d1_s4  <= sp_hu.digit;
			rem_s4 <= sp_hu.rest[6:0];
			ctl_s4 <= ctl_s3;
		end
		if (go_s5) begin
			d0_s5  <= d0_s4;
			d1_s5  <= d1_s4;
			d2_s5  <= sp_te.digit;
			d3_s5  <= sp_te.rest[3:0];
			ctl_s5 <= ctl_s4;
		end
	end

	assign dn_valid     = v_s5;
	assign dn_digits[0] = d0_s5;
	assign dn_digits[1] = d1_s5;
	assign dn_digits[2] = d2_s5;
	assign dn_digits[3] = d3_s5;
	assign dn_ctl       = ctl_s5;

endmodule

// ===== hw/rtl/ssbf_seg.sv =====
// ssbf_seg: segment encoding with blanking and dot, result output register
// depends on ssbf_pkg and ssbf_if

module ssbf_seg (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  up_valid,
	output logic                  up_ready,
	input  ssbf_pkg::bcd_word_t   up_digits,
	input  ssbf_pkg::ssbf_ctl_t   up_ctl,
	ssbf_result_if.source         result
);

	logic       valid_q;
	logic       go;
	logic [7:0] seg_d [ssbf_pkg::DIGIT_COUNT];
	logic [7:0] seg_q [ssbf_pkg::DIGIT_COUNT];
	logic       blank_q;

	assign go       = !valid_q || result.ready;
	assign up_ready = go;

	// encode each digit, blank the blink digit in the blank phase, then add the dot
	// dot positions reach only the three leftmost digits
	always_comb begin
		for (int i = 0; i < ssbf_pkg::DIGIT_COUNT; i++) begin
			seg_d[i] = {1'b0, ssbf_pkg::seg_code(up_digits[i])};
			if (up_ctl.blank && (up_ctl.blink_position == 3'(i))) begin
				seg_d[i][6:0] = ssbf_pkg::SEG_OFF;
			end
			if ((i < ssbf_pkg::DIGIT_COUNT - 1) && (up_ctl.dot_position == 3'(i + 1))) begin
				seg_d[i] = seg_d[i] | ssbf_pkg::DOT_BIT;
			end
		end
	end

	// result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (go) begin
			valid_q <= up_valid;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (go && up_valid) begin
			seg_q   <= seg_d;
			blank_q <= up_ctl.blank;
		end
	end

	assign result.valid       = valid_q;
	assign result.digit_one   = seg_q[0];
	assign result.digit_two   = seg_q[1];
	assign result.digit_three = seg_q[2];
	assign result.digit_four  = seg_q[3];
	assign result.blank_phase = blank_q;

endmodule

// ===== hw/rtl/seven_segment_blink_formatter.sv =====
// seven_segment_blink_formatter: top level of the four digit display formatter with blink
// depends on ssbf_pkg, ssbf_if, ssbf_phase, ssbf_bcd and ssbf_seg
//
//   channel  dir  payload                                          handshake
//   tick     in   value, blink_position, dot_position              valid/ready
//   result   out  digit_one..digit_four, blank_phase               valid/ready
//   cfg      in   half_period                                      valid/ready, ready tied high
//
// one item per cycle unless the result stalls; a taken tick passes through
// six registers: input, mod 10000, three digit split stages, segment register
// reset empties the pipeline, clears the tick count, starts in the blank phase
// and loads half_period with 500
// a stalled result holds; earlier stages keep filling bubbles and tick.ready
// drops only when every stage holds an item

module seven_segment_blink_formatter (
	input  logic          clk,
	input  logic          arst_n,
	ssbf_cfg_if.sink      cfg,
	ssbf_tick_if.sink     tick,
	ssbf_result_if.source result
);

	logic                tick_ready;
	logic                tick_fire;
	logic                blank;
	ssbf_pkg::ssbf_ctl_t tick_ctl;
	logic                bcd_valid;
	logic                seg_ready;
	ssbf_pkg::bcd_word_t bcd_digits;
	ssbf_pkg::ssbf_ctl_t bcd_ctl;

	assign tick.ready = tick_ready;
	assign tick_fire  = tick.valid && tick_ready;

	// blink phase and half period register
	ssbf_phase u_phase (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_valid       (cfg.valid),
		.cfg_ready       (cfg.ready),
		.cfg_half_period (cfg.half_period),
		.tick_fire       (tick_fire),
		.blank           (blank)
	);

	// control travels with the item
	always_comb begin
		tick_ctl.blink_position = tick.blink_position;
		tick_ctl.dot_position   = tick.dot_position;
		tick_ctl.blank          = blank;
	end

	// decimal digit split
	ssbf_bcd u_bcd (
		.clk       (clk),
		.arst_n    (arst_n),
		.up_valid  (tick.valid),
		.up_ready  (tick_ready),
		.up_value  (tick.value),
		.up_ctl    (tick_ctl),
		.dn_valid  (bcd_valid),
		.dn_ready  (seg_ready),
		.dn_digits (bcd_digits),
		.dn_ctl    (bcd_ctl)
	);

	// segment encoding and result register
	ssbf_seg u_seg (
		.clk       (clk),
		.arst_n    (arst_n),
		.up_valid  (bcd_valid),
		.up_ready  (seg_ready),
		.up_digits (bcd_digits),
		.up_ctl    (bcd_ctl),
		.result    (result)
	);

endmodule
